### hdl/yuv_rgb_pkg.sv
// yuv_rgb_pkg: item types, coefficients and stage widths of the yuyv to rgb converter
// no dependencies; imported by yuyv_to_rgb_converter_core
package yuv_rgb_pkg;

    localparam int SUM_W      = 22;
    localparam int OFS_W      = 9;
    localparam int DIV_W      = 18;
    localparam int RECIP_W    = 19;
    localparam int SHIFT      = 28;
    localparam int RECIP      = 268436;
    localparam int SAT_LIMIT  = 256000;
    localparam int LAT        = 6;
    localparam int N_CH       = 6;

    localparam int LUMA_GAIN    = 1164;
    localparam int RED_V_GAIN   = 1159;
    localparam int GREEN_U_GAIN = 380;
    localparam int GREEN_V_GAIN = 813;
    localparam int BLUE_U_GAIN  = 2018;
    localparam int CHROMA_MID   = 128;
    localparam int LUMA_FLOOR   = 16;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [OFS_W-1:0] t_ofs;

    typedef enum logic [1:0] {
        CL_PASS = 2'd0,
        CL_ZERO = 2'd1,
        CL_FULL = 2'd2
    } t_clamp;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } t_yuyv_item;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } t_rgb_pair;

endpackage

### hdl/yuyv_to_rgb_converter_core.sv
// yuyv_to_rgb_converter_core: six-stage pipeline, one yuyv macropixel in, two rgb888 pixels out
// depends on yuv_rgb_pkg for item types, coefficients and widths
//
//  channel  | ports                    | flow
//  ---------+--------------------------+-----------------------------------------
//  item in  | start, busy, i_item      | taken when start is high and busy is low
//  item out | o_valid, o_result        | one-cycle strobe, no back-pressure
//
// an item enters every cycle; busy is never raised
// each item passes through offsets, products, green sum,
// channel sums, reciprocal multiply for the divide by 1000, clamp
// synchronous active-low reset clears the valid bits only
// nothing stalls, since the receiver always takes the result
module yuyv_to_rgb_converter_core
    import yuv_rgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_yuyv_item i_item,
    output logic       o_valid,
    output t_rgb_pair  o_result
);

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    // stage 1: offsets
    t_ofs r_y0, r_y1, r_cb, r_cr;
    // stage 2: products
    t_sum r_l0, r_l1, r_rt, r_gu, r_gv, r_bt;
    // stage 3: green term
    t_sum r3_l0, r3_l1, r3_rt, r3_gt, r3_bt;
    // stage 4: channel sums
    t_sum r_sum [N_CH];
    // stage 5: reciprocal products and clamp codes
    logic [DIV_W+RECIP_W-1:0] r_prod [N_CH];
    t_clamp                   r_cl   [N_CH];
    // stage 6: result
    logic [7:0] r_ch [N_CH];

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LAT-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y0 <= t_ofs'({1'b0, i_item.luma_first})  - t_ofs'(LUMA_FLOOR);
        r_y1 <= t_ofs'({1'b0, i_item.luma_second}) - t_ofs'(LUMA_FLOOR);
        r_cb <= t_ofs'({1'b0, i_item.chroma_blue}) - t_ofs'(CHROMA_MID);
        r_cr <= t_ofs'({1'b0, i_item.chroma_red})  - t_ofs'(CHROMA_MID);

        r_l0 <= t_sum'(r_y0) * t_sum'(LUMA_GAIN);
        r_l1 <= t_sum'(r_y1) * t_sum'(LUMA_GAIN);
        r_rt <= t_sum'(r_cr) * t_sum'(RED_V_GAIN);
        r_gu <= t_sum'(r_cb) * t_sum'(GREEN_U_GAIN);
        r_gv <= t_sum'(r_cr) * t_sum'(GREEN_V_GAIN);
        r_bt <= t_sum'(r_cb) * t_sum'(BLUE_U_GAIN);

        r3_l0 <= r_l0;
        r3_l1 <= r_l1;
        r3_rt <= r_rt;
        r3_gt <= r_gu + r_gv;
        r3_bt <= r_bt;

        r_sum[0] <= r3_l0 + r3_rt;
        r_sum[1] <= r3_l0 - r3_gt;
        r_sum[2] <= r3_l0 + r3_bt;
        r_sum[3] <= r3_l1 + r3_rt;
        r_sum[4] <= r3_l1 - r3_gt;
        r_sum[5] <= r3_l1 + r3_bt;
    end

    // divide by 1000 as multiply by a rounded-up reciprocal, exact below the clamp limit
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_CH; i++) begin
            r_prod[i] <= (DIV_W+RECIP_W)'(r_sum[i][DIV_W-1:0])
                       * (DIV_W+RECIP_W)'(RECIP);
            if (r_sum[i][SUM_W-1]) begin
                r_cl[i] <= CL_ZERO;
            end else if (r_sum[i] >= t_sum'(SAT_LIMIT)) begin
                r_cl[i] <= CL_FULL;
            end else begin
                r_cl[i] <= CL_PASS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_CH; i++) begin
            unique case (r_cl[i])
                CL_ZERO: r_ch[i] <= 8'd0;
                CL_FULL: r_ch[i] <= 8'd255;
                default: r_ch[i] <= r_prod[i][SHIFT+7:SHIFT];
            endcase
        end
    end

    assign o_valid               = r_vld[LAT-1];
    assign o_result.red_first    = r_ch[0];
    assign o_result.green_first  = r_ch[1];
    assign o_result.blue_first   = r_ch[2];
    assign o_result.red_second   = r_ch[3];
    assign o_result.green_second = r_ch[4];
    assign o_result.blue_second  = r_ch[5];

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without an item taken six cycles earlier");

    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_item.chroma_red, LAT) == 8'd128
                 && $past(i_item.luma_first, LAT) < 8'd16)
        |-> o_result.red_first == 8'd0)
        else $error("red below black level not clamped to zero");

    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_item.chroma_red, LAT) == 8'd128
                 && $past(i_item.chroma_blue, LAT) == 8'd128
                 && $past(i_item.luma_second, LAT) == 8'd255)
        |-> (o_result.red_second == 8'd255 && o_result.green_second == 8'd255
             && o_result.blue_second == 8'd255))
        else $error("full-scale grey not saturated");
`endif

endmodule
